@@ rtl/bwhm_pkg.sv @@
// ----------------------------------------------------------------------------
// bwhm_pkg
// Types and constants shared by the battery watt-hour meter modules.
// ----------------------------------------------------------------------------
package bwhm_pkg;

	// operation codes
	localparam logic [2:0] OP_TICK       = 3'd0;
	localparam logic [2:0] OP_STORE_TRIP = 3'd1;
	localparam logic [2:0] OP_ZERO_WH    = 3'd2;
	localparam logic [2:0] OP_ZERO_TRIP  = 3'd3;
	localparam logic [2:0] OP_ADD_GRID   = 3'd4;

	// configuration register indexes
	localparam int unsigned CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_LOOP_PERIOD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_MIN_SESSION = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_DISPLAY     = 2'd2;
	localparam int unsigned CFG_DATA_W = 16;

	// reset values of the configuration registers
	localparam logic [7:0]  LOOP_PERIOD_RST = 8'd10;
	localparam logic [15:0] MIN_SESSION_RST = 16'd10;

	// energy arithmetic
	localparam logic [6:0]  ENERGY_SCALE = 7'd114;
	localparam int unsigned PROD_A_W     = 24;       // |amps| * volts
	localparam int unsigned PROD_B_W     = 32;       // ... * period
	localparam int unsigned PROD_C_W     = 39;       // ... * 114
	localparam int unsigned ENERGY_SHIFT = 12;
	localparam int unsigned ENERGY_W     = PROD_C_W - ENERGY_SHIFT;
	localparam int unsigned REM_W        = 20;
	localparam int unsigned SUM_W        = 28;
	// largest sum is just over 60 Wh worth of uWh, so six quotient bits
	localparam int unsigned QUO_W        = 6;
	localparam logic [SUM_W-1:0] UWH_PER_WH = 28'd1000000;
	// floor(sum / 1e6) as (sum * RECIP_M) >> RECIP_SHIFT; exact for any sum
	// below 2^26, which covers remainder plus the largest tick energy
	localparam int unsigned RECIP_W      = 27;
	localparam int unsigned RECIP_SHIFT  = 46;
	localparam logic [RECIP_W-1:0] RECIP_M = 27'd70368745;
	localparam int unsigned RECIP_PROD_W = SUM_W + RECIP_W;
	localparam logic [15:0] WH_MAX = 16'hFFFF;

	typedef struct packed {
		logic [2:0]         operation;
		logic [31:0]        now_ms;
		logic signed [15:0] current_deciamps;
		logic [7:0]         pack_volts;
		logic               key_on;
		logic               grid_plugged;
		logic [31:0]        seconds_since_key_on;
		logic [31:0]        grid_trip_wh;
	} in_item_t;

	typedef struct packed {
		logic [15:0] assist_wh;
		logic [15:0] regen_wh;
		logic [31:0] grid_wh;
		logic [31:0] trip_assist_wh;
		logic [31:0] trip_regen_wh;
		logic [31:0] trip_grid_wh;
		logic        store_session;
		logic [31:0] session_seconds;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic latch;      // capture the accepted transaction
		logic decode;     // run simple ops, or start the tick product
		logic mul_b;
		logic mul_c;
		logic prep;       // scale energy, add remainder
		logic quo;        // whole watt-hours by reciprocal multiply
		logic rem;        // uWh left over after the whole watt-hours
		logic acc;        // fold whole watt-hours into the counters
		logic load_out;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic tick_active;
	} sts_t;

endpackage

@@ rtl/battery_watt_hour_meter_core.sv @@
// ----------------------------------------------------------------------------
// battery_watt_hour_meter_core
// Battery energy meter: integrates current x voltage x time into assist,
// regen and grid watt-hour counters and keeps trip meters.
// ----------------------------------------------------------------------------
//
//  channel  | signals                          | moves
//  ---------+----------------------------------+------------------------------
//  in       | in_valid, in_stall, in_data      | one operation per transaction
//  out      | out_valid, out_stall, out_data   | counters after the operation
//  cfg      | cfg_we, cfg_index, cfg_data      | register write, no wait
//
//  A tick that accumulates runs from acceptance back to ready through three
//  multiplier stages, a prepare step, a reciprocal multiply and a remainder
//  step for the uWh-to-Wh split, then update and output load. Every other
//  operation goes from decode to output load. One transaction is worked on at a
//  time. A result held under out_stall does not block acceptance of the next
//  transaction; only the output load waits for the slot to free up.
//  Reset is asynchronous, active low; counters and configuration come up at
//  their defaults, no clearing pass.
//
module battery_watt_hour_meter_core (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bwhm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bwhm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_stall,
	input  bwhm_pkg::in_item_t                in_data,
	output logic                              out_valid,
	input  logic                              out_stall,
	output bwhm_pkg::out_item_t               out_data
);
	import bwhm_pkg::*;

	cmd_t cmd;   // sequencer commands
	sts_t sts;   // datapath status back to the sequencer

	// control: state machine and handshakes
	bwhm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	// datapath: config registers, counters, multiplier chain, uWh-to-Wh
	// split, output register
	bwhm_datapath u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_data   (in_data),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (out_data)
	);

endmodule

@@ rtl/bwhm_datapath.sv @@
// ----------------------------------------------------------------------------
// bwhm_datapath
// Counters, configuration, energy multiplier chain, uWh-to-Wh split and the
// output register of the watt-hour meter.
// ----------------------------------------------------------------------------
module bwhm_datapath (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [bwhm_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [bwhm_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  bwhm_pkg::in_item_t                   in_data,
	input  bwhm_pkg::cmd_t                       cmd,
	output bwhm_pkg::sts_t                       sts,
	output bwhm_pkg::out_item_t                  out_data
);
	import bwhm_pkg::*;

	// configuration
	logic [7:0]  loop_period_q;
	logic [15:0] min_session_q;
	logic        display_q;

	// meter state
	logic [15:0]      assist_q, regen_q;
	logic [31:0]      grid_q, trip_assist_q, trip_regen_q, trip_grid_q;
	logic [REM_W-1:0] assist_rem_q, regen_rem_q;
	logic [31:0]      last_tick_q;
	logic             flag_q;
	logic [31:0]      flag_secs_q;

	in_item_t item_q;

	// product chain
	logic [PROD_A_W-1:0] prod_s1;
	logic [PROD_B_W-1:0] prod_s2;
	logic [PROD_C_W-1:0] prod_s3;
	logic [7:0]          period_s1;
	logic                neg_s1;

	// uWh-to-Wh split
	logic [SUM_W-1:0] div_r_q;
	logic [QUO_W-1:0] quo_q;
	logic             regen_path_q;

	logic [7:0]              period;
	logic                    long_gap;
	logic [15:0]             amp_mag;
	logic                    flag_now;
	logic [ENERGY_W-1:0]     energy_floor;
	logic                    round_up;
	logic                    regen_path;
	logic [REM_W-1:0]        rem_sel;
	logic [RECIP_PROD_W-1:0] recip_prod;
	logic [16:0]             assist_sum, regen_sum;

	assign sts.tick_active = (item_q.operation == OP_TICK) &&
		(item_q.key_on || (display_q && item_q.grid_plugged));

	assign period   = item_q.now_ms[7:0] - last_tick_q[7:0];
	assign long_gap = {2'b00, period} > {loop_period_q, 2'b00};
	assign amp_mag  = item_q.current_deciamps[15] ?
		(~item_q.current_deciamps + 16'd1) : item_q.current_deciamps;
	assign flag_now = (item_q.operation == OP_STORE_TRIP) &&
		((regen_q > min_session_q) || (assist_q > min_session_q));

	// floor for positive energy, ceiling of magnitude for negative
	assign energy_floor = prod_s3[PROD_C_W-1:ENERGY_SHIFT];
	assign round_up     = neg_s1 && (|prod_s3[ENERGY_SHIFT-1:0]);
	assign regen_path   = neg_s1 && (prod_s3 != '0);
	assign rem_sel      = regen_path ? regen_rem_q : assist_rem_q;
	assign recip_prod   = RECIP_PROD_W'(div_r_q) * RECIP_PROD_W'(RECIP_M);

	assign assist_sum = {1'b0, assist_q} + {11'd0, quo_q};
	assign regen_sum  = {1'b0, regen_q} + {11'd0, quo_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loop_period_q <= LOOP_PERIOD_RST;
			min_session_q <= MIN_SESSION_RST;
			display_q     <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LOOP_PERIOD: loop_period_q <= cfg_data[7:0];
				CFG_MIN_SESSION: min_session_q <= cfg_data;
				CFG_DISPLAY:     display_q     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			assist_q      <= '0;
			regen_q       <= '0;
			grid_q        <= '0;
			trip_assist_q <= '0;
			trip_regen_q  <= '0;
			trip_grid_q   <= '0;
			assist_rem_q  <= '0;
			regen_rem_q   <= '0;
			last_tick_q   <= '0;
			flag_q        <= 1'b0;
			flag_secs_q   <= '0;
		end else begin
			if (cmd.decode) begin
				flag_q      <= flag_now;
				flag_secs_q <= flag_now ? item_q.seconds_since_key_on : 32'd0;
				if (sts.tick_active) begin
					last_tick_q <= item_q.now_ms;
				end else begin
					case (item_q.operation)
						OP_STORE_TRIP: begin
							if (display_q) begin
								trip_assist_q <= trip_assist_q + {16'd0, assist_q};
								trip_regen_q  <= trip_regen_q + {16'd0, regen_q};
							end else begin
								assist_q <= '0;
								regen_q  <= '0;
								grid_q   <= '0;
							end
						end
						OP_ZERO_WH: begin
							assist_q <= '0;
							regen_q  <= '0;
							grid_q   <= '0;
						end
						OP_ZERO_TRIP: begin
							trip_assist_q <= '0;
							trip_regen_q  <= '0;
							trip_grid_q   <= '0;
						end
						OP_ADD_GRID: trip_grid_q <= trip_grid_q + item_q.grid_trip_wh;
						default: ;
					endcase
				end
			end
			if (cmd.acc) begin
				if (regen_path_q) begin
					regen_rem_q <= div_r_q[REM_W-1:0];
					if ((quo_q != '0) && (regen_q != WH_MAX)) begin
						if (item_q.grid_plugged) begin
							grid_q <= grid_q + {26'd0, quo_q};
						end else begin
							regen_q <= regen_sum[16] ? WH_MAX : regen_sum[15:0];
						end
					end
				end else begin
					assist_rem_q <= div_r_q[REM_W-1:0];
					if (quo_q != '0) begin
						assist_q <= assist_sum[16] ? WH_MAX : assist_sum[15:0];
					end
				end
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			item_q <= in_data;
		end
		if (cmd.decode) begin
			period_s1 <= long_gap ? 8'd0 : period;
			neg_s1    <= item_q.current_deciamps[15];
			prod_s1   <= PROD_A_W'(amp_mag) * PROD_A_W'(item_q.pack_volts);
		end
		if (cmd.mul_b) begin
			prod_s2 <= PROD_B_W'(prod_s1) * PROD_B_W'(period_s1);
		end
		if (cmd.mul_c) begin
			prod_s3 <= PROD_C_W'(prod_s2) * PROD_C_W'(ENERGY_SCALE);
		end
		if (cmd.prep) begin
			div_r_q      <= SUM_W'(rem_sel) + SUM_W'(energy_floor) + SUM_W'(round_up);
			regen_path_q <= regen_path;
		end
		if (cmd.quo) begin
			quo_q <= recip_prod[RECIP_SHIFT +: QUO_W];
		end
		if (cmd.rem) begin
			div_r_q <= div_r_q - (SUM_W'(quo_q) * UWH_PER_WH);
		end
		if (cmd.load_out) begin
			out_data.assist_wh       <= assist_q;
			out_data.regen_wh        <= regen_q;
			out_data.grid_wh         <= grid_q;
			out_data.trip_assist_wh  <= trip_assist_q;
			out_data.trip_regen_wh   <= trip_regen_q;
			out_data.trip_grid_wh    <= trip_grid_q;
			out_data.store_session   <= flag_q;
			out_data.session_seconds <= flag_secs_q;
		end
	end

endmodule

@@ rtl/bwhm_ctrl.sv @@
// ----------------------------------------------------------------------------
// bwhm_ctrl
// Sequencer for the watt-hour meter: handshakes and step order.
// ----------------------------------------------------------------------------
module bwhm_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	output logic            in_stall,
	output logic            out_valid,
	input  logic            out_stall,
	input  bwhm_pkg::sts_t  sts,
	output bwhm_pkg::cmd_t  cmd
);
	import bwhm_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b0_0000_0001,
		ST_DECODE = 9'b0_0000_0010,
		ST_MUL_B  = 9'b0_0000_0100,
		ST_MUL_C  = 9'b0_0000_1000,
		ST_PREP   = 9'b0_0001_0000,
		ST_QUO    = 9'b0_0010_0000,
		ST_REM    = 9'b0_0100_0000,
		ST_ACC    = 9'b0_1000_0000,
		ST_EMIT   = 9'b1_0000_0000
	} state_t;

	state_t state_q, state_d;
	logic   out_valid_q;
	logic   out_free;

	assign out_free  = !out_valid_q || !out_stall;
	assign in_stall  = state_q != ST_IDLE;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd      = '0;
		state_d  = state_q;
		case (state_q)
			ST_IDLE: begin
				cmd.latch = in_valid;
				if (in_valid) begin
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				cmd.decode = 1'b1;
				state_d    = sts.tick_active ? ST_MUL_B : ST_EMIT;
			end
			ST_MUL_B: begin
				cmd.mul_b = 1'b1;
				state_d   = ST_MUL_C;
			end
			ST_MUL_C: begin
				cmd.mul_c = 1'b1;
				state_d   = ST_PREP;
			end
			ST_PREP: begin
				cmd.prep = 1'b1;
				state_d  = ST_QUO;
			end
			ST_QUO: begin
				cmd.quo = 1'b1;
				state_d = ST_REM;
			end
			ST_REM: begin
				cmd.rem = 1'b1;
				state_d = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				cmd.load_out = out_free;
				if (out_free) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

@@ rtl/bwhm_checker.sv @@
// ----------------------------------------------------------------------------
// bwhm_checker
// Port-level checks for the watt-hour meter, bound to the top level.
// ----------------------------------------------------------------------------
module bwhm_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bwhm_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [bwhm_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	input  logic                              in_stall,
	input  bwhm_pkg::in_item_t                in_data,
	input  logic                              out_valid,
	input  logic                              out_stall,
	input  bwhm_pkg::out_item_t               out_data
);
	import bwhm_pkg::*;

	// held result stays put
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_data))
		else $error("output changed while stalled");

	// one transaction in flight: accept is followed by a busy cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("input taken again right after acceptance");

	// duration only travels with a flagged session
	a_secs_only_flagged: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_data.store_session |-> out_data.session_seconds == 32'd0)
		else $error("session seconds without store flag");

	// a new result needs a fresh transaction; none while idle and empty
	a_no_spurious_out: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid && !in_stall |=> !out_valid)
		else $error("result without transaction");

endmodule

bind battery_watt_hour_meter_core bwhm_checker u_bwhm_checker (.*);
